// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LFU_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LFU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LFU_ASSERT(lbl, clk, rst, prop, msg)
`define LFU_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/lfu_pkg.sv =====
// ----------------------------------------------------------------------------
// LFU cache package
// Sizes and the scan result type shared by the cache controller files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfu_pkg;

  localparam int ENTRIES    = 16;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int OCC_W      = $clog2(ENTRIES + 1);
  localparam int RANK_W     = IDX_W;
  localparam int CNT_W      = 32;
  localparam int KEY_W      = 32;
  localparam int DATA_W     = 32;
  localparam int CAP_W      = 5;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // Outcome of one full pass over the entries.
  typedef struct packed {
    logic              match;
    logic [IDX_W-1:0]  midx;
    logic [DATA_W-1:0] mdata;
    logic [CNT_W-1:0]  mcnt;
    logic              vfound;
    logic [IDX_W-1:0]  vidx;
  } scan_res_t;

endpackage

// ===== rtl/lfu_scan.sv =====
// ----------------------------------------------------------------------------
// LFU scan unit
// Shared compare unit: one entry per cycle while en is high, for key match and victim choice.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfu_scan (
  input  logic                        clk,
  input  logic                        clear,
  input  logic                        en,
  input  logic [lfu_pkg::IDX_W-1:0]   idx,
  input  logic                        ent_valid,
  input  logic [lfu_pkg::KEY_W-1:0]   ent_key,
  input  logic [lfu_pkg::DATA_W-1:0]  ent_data,
  input  logic [lfu_pkg::CNT_W-1:0]   ent_cnt,
  input  logic [lfu_pkg::RANK_W-1:0]  ent_rank,
  input  logic [lfu_pkg::KEY_W-1:0]   key,
  output lfu_pkg::scan_res_t          res
);

  logic [lfu_pkg::CNT_W-1:0]  vcnt;
  logic [lfu_pkg::RANK_W-1:0] vrank;
  logic                       take_victim;

  // Lower count wins; on equal counts the entry touched longer ago wins.
  assign take_victim = ent_valid &&
                       (!res.vfound || (ent_cnt < vcnt) ||
                        ((ent_cnt == vcnt) && (ent_rank > vrank)));

  always_ff @(posedge clk) begin
    if (clear) begin
      res.match  <= 1'b0;
      res.vfound <= 1'b0;
    end else if (en) begin
      if (ent_valid && (ent_key == key) && !res.match) begin
        res.match <= 1'b1;
        res.midx  <= idx;
        res.mdata <= ent_data;
        res.mcnt  <= ent_cnt;
      end
      if (take_victim) begin
        res.vfound <= 1'b1;
        res.vidx   <= idx;
        vcnt       <= ent_cnt;
        vrank      <= ent_rank;
      end
    end
  end

endmodule

// ===== rtl/lfu_cache_controller_unit.sv =====
// ----------------------------------------------------------------------------
// LFU cache controller
// Key-value store with least-frequently-used replacement, oldest touch first.
// ----------------------------------------------------------------------------
//  Channel   | Signals                                  | Direction
//  ----------+------------------------------------------+----------
//  request   | in_valid, in_stall, req_type, key, value | in
//  result    | out_valid, out_stall, hit, read_value,   | out
//            | evicted                                  |
//  config    | capacity_we, capacity_wdata              | in
//
// A request is accepted in the idle state and then passes through the scan,
// the update step, the insert step when a new key is inserted, and the finish
// step. During the scan one entry is issued per cycle to the registered read
// of the key, data and count memories; the scan then waits for that read to
// drain and for the shared scan unit to settle. The finish step loads the
// output register.
// Reset (synchronous, active high) clears all valid bits, the occupancy and
// the handshake state, and sets the capacity to 16.
// The request side stalls whenever a request is in progress. A result beat
// held by a stalled consumer keeps the controller in its final state until
// the output register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lfu_cache_controller_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              capacity_we,
  input  logic [lfu_pkg::CAP_W-1:0]         capacity_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              req_type,
  input  logic signed [lfu_pkg::KEY_W-1:0]  key,
  input  logic signed [lfu_pkg::DATA_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              hit,
  output logic signed [lfu_pkg::DATA_W-1:0] read_value,
  output logic                              evicted
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_UPDATE = 5'b00100,
    S_INSERT = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state;

  // Capacity register and its clamp to the number of entries.
  logic [lfu_pkg::CAP_W-1:0] capacity;
  logic [lfu_pkg::OCC_W-1:0] cap_eff;

  assign cap_eff = (capacity > lfu_pkg::CAP_W'(lfu_pkg::ENTRIES)) ?
                   lfu_pkg::OCC_W'(lfu_pkg::ENTRIES) :
                   lfu_pkg::OCC_W'(capacity);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lfu_pkg::CAP_W'(16);
    end else if (capacity_we) begin
      capacity <= capacity_wdata;
    end
  end

  // Latched request.
  logic                       req_set;
  logic [lfu_pkg::KEY_W-1:0]  req_key;
  logic [lfu_pkg::DATA_W-1:0] req_val;

  // Valid bits and touch ranks live in flops; each entry updates in parallel.
  logic [lfu_pkg::ENTRIES-1:0] valid;
  logic [lfu_pkg::RANK_W-1:0]  rank [lfu_pkg::ENTRIES];
  logic [lfu_pkg::OCC_W-1:0]   occupancy;

  // Key, data and count memories, read one entry per cycle during the scan.
  logic [lfu_pkg::KEY_W-1:0]  key_mem  [lfu_pkg::ENTRIES];
  logic [lfu_pkg::DATA_W-1:0] data_mem [lfu_pkg::ENTRIES];
  logic [lfu_pkg::CNT_W-1:0]  cnt_mem  [lfu_pkg::ENTRIES];
  logic [lfu_pkg::KEY_W-1:0]  key_q;
  logic [lfu_pkg::DATA_W-1:0] data_q;
  logic [lfu_pkg::CNT_W-1:0]  cnt_q;

  logic [lfu_pkg::OCC_W-1:0]  scan_idx;
  logic                       issue;
  logic                       pvalid;
  logic [lfu_pkg::IDX_W-1:0]  pidx;

  assign issue = (state == S_SCAN) && (scan_idx < lfu_pkg::OCC_W'(lfu_pkg::ENTRIES));

  always_ff @(posedge clk) begin
    key_q  <= key_mem[scan_idx[lfu_pkg::IDX_W-1:0]];
    data_q <= data_mem[scan_idx[lfu_pkg::IDX_W-1:0]];
    cnt_q  <= cnt_mem[scan_idx[lfu_pkg::IDX_W-1:0]];
    pidx   <= scan_idx[lfu_pkg::IDX_W-1:0];
  end

  // Scan results.
  lfu_pkg::scan_res_t sr;

  lfu_scan u_scan (
    .clk       (clk),
    .clear     (state == S_IDLE),
    .en        (pvalid),
    .idx       (pidx),
    .ent_valid (valid[pidx]),
    .ent_key   (key_q),
    .ent_data  (data_q),
    .ent_cnt   (cnt_q),
    .ent_rank  (rank[pidx]),
    .key       (req_key),
    .res       (sr)
  );

  // Decisions taken in the update cycle.
  logic do_touch;
  logic do_evict;
  logic to_insert;

  always_comb begin
    do_touch  = 1'b0;
    do_evict  = 1'b0;
    to_insert = 1'b0;
    if (!req_set) begin
      do_touch = sr.match;
    end else if (cap_eff != '0) begin
      if (sr.match) begin
        do_touch = 1'b1;
      end else begin
        to_insert = 1'b1;
        do_evict  = (occupancy >= cap_eff);
      end
    end
  end

  // The lowest free slot, looked up once the victim is gone.
  logic                      free_found;
  logic [lfu_pkg::IDX_W-1:0] free_idx;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = lfu_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_found = 1'b1;
        free_idx   = lfu_pkg::IDX_W'(i);
      end
    end
  end

  logic                       do_insert;
  logic [lfu_pkg::CNT_W-1:0]  cnt_inc;

  assign do_insert = (state == S_INSERT) && free_found;
  assign cnt_inc   = (sr.mcnt == lfu_pkg::COUNT_MAX) ? sr.mcnt : sr.mcnt + 1'b1;

  // One write port per memory.
  always_ff @(posedge clk) begin
    if (do_insert) begin
      key_mem[free_idx]  <= req_key;
      data_mem[free_idx] <= req_val;
      cnt_mem[free_idx]  <= lfu_pkg::CNT_W'(1);
    end else if ((state == S_UPDATE) && do_touch) begin
      cnt_mem[sr.midx] <= cnt_inc;
      if (req_set) begin
        data_mem[sr.midx] <= req_val;
      end
    end
  end

  // Valid bits, ranks and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      occupancy <= '0;
    end else if (state == S_UPDATE) begin
      if (do_touch) begin
        for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
          if (valid[i] && (lfu_pkg::IDX_W'(i) != sr.midx) && (rank[i] < rank[sr.midx])) begin
            rank[i] <= rank[i] + 1'b1;
          end
        end
        rank[sr.midx] <= '0;
      end else if (do_evict && sr.vfound) begin
        valid[sr.vidx] <= 1'b0;
        for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
          if (valid[i] && (rank[i] > rank[sr.vidx])) begin
            rank[i] <= rank[i] - 1'b1;
          end
        end
        if (occupancy != '0) begin
          occupancy <= occupancy - 1'b1;
        end
      end
    end else if (do_insert) begin
      for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
        if (valid[i]) begin
          rank[i] <= rank[i] + 1'b1;
        end
      end
      valid[free_idx] <= 1'b1;
      rank[free_idx]  <= '0;
      occupancy       <= occupancy + 1'b1;
    end
  end

  // Result being built.
  logic                       res_hit;
  logic [lfu_pkg::DATA_W-1:0] res_rv;
  logic                       res_ev;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      pvalid    <= 1'b0;
      scan_idx  <= '0;
    end else begin
      pvalid <= issue;
      // The output register is loaded from the finish step once it is free.
      if ((state == S_FINISH) && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_set  <= req_type;
            req_key  <= key;
            req_val  <= value;
            res_hit  <= 1'b0;
            res_rv   <= '0;
            res_ev   <= 1'b0;
            scan_idx <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (issue) begin
            scan_idx <= scan_idx + 1'b1;
          end else if (!pvalid) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (sr.match) begin
            res_hit <= 1'b1;
            res_rv  <= (req_set && (cap_eff != '0)) ? req_val : sr.mdata;
          end
          res_ev <= do_evict;
          state  <= to_insert ? S_INSERT : S_FINISH;
        end
        S_INSERT: begin
          if (free_found) begin
            res_rv <= req_val;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || !out_stall) begin
            hit        <= res_hit;
            read_value <= res_rv;
            evicted    <= res_ev;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `LFU_ASSERT(a_occ_matches_valid, clk, rst, (state == S_IDLE) |-> ($countones(valid) == 32'(occupancy)), "occupancy disagrees with valid bits")
  `LFU_ASSERT(a_accept_busy, clk, rst, (in_valid && !in_stall) |=> (state == S_SCAN), "accepted request did not start a scan")
  `LFU_ASSERT(a_result_from_finish, clk, rst, $rose(out_valid) |-> $past(state == S_FINISH), "result appeared outside the finish step")
  `LFU_ASSERT_ALWAYS(a_occ_bound, clk, rst || (occupancy <= lfu_pkg::OCC_W'(lfu_pkg::ENTRIES)), "occupancy above entry count")

endmodule
